// ===== rtl/bblur_pkg.sv =====
// ---------------------------------------------------------------------------
// bblur_pkg
// Types and constants shared by the 3x3 RGB box blur modules.
// ---------------------------------------------------------------------------
`default_nettype none

package bblur_pkg;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned PIX_W      = 3 * CH_W;
  localparam int unsigned SUM_W      = 12;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned WIDTH_REG_W = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned JOB_QUEUE_DEPTH = 4;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [ROW_W-1:0]       HEIGHT_RESET = 16'd480;

  // Division by nine as multiplication by ceil(2^16 / 9) and a shift; exact
  // for every sum of nine 8-bit samples.
  localparam int unsigned RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;
  localparam int unsigned RECIP_SHIFT = 16;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic pixel;
    logic has_out;
    logic drain;
    logic interior;
    logic sel_lower;
    logic last;
  } job_flags_t;

endpackage

`default_nettype wire

// ===== rtl/box_blur_3x3_rgb.sv =====
// ---------------------------------------------------------------------------
// box_blur_3x3_rgb
// A result appears on m_axis after the job queue and s1, s2, s3 registers;
// pixel results belong to the pixel one row plus one pixel before it.
// Throughput is one transfer per cycle while not stalled, set by the single
// line-buffer RAM port pair that each pixel reads and writes once.
// Reset restores width 640 and height 480 and clears the frame position and
// all valid flags; the line buffers are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // red_in [7:0], green_in [15:8], blue_in [23:16]
  input  logic [bblur_pkg::PIX_W-1:0]      s_axis_tdata,
  // op
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // red_out [7:0], green_out [15:8], blue_out [23:16]
  output logic [bblur_pkg::PIX_W-1:0]      m_axis_tdata,
  output logic                             m_axis_tlast,
  input  logic                             cfg_we,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bblur_pkg::CFG_DATA_W-1:0] cfg_data
);

  import bblur_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int JOB_W = $bits(job_flags_t) + CW + PIX_W;

  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  logic [JOB_W-1:0] q_in;
  logic [JOB_W-1:0] q_out;

  bblur_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  bblur_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  bblur_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (q_out),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/bblur_ram.sv =====
// ---------------------------------------------------------------------------
// bblur_ram
// Simple dual-port RAM with one write port and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module bblur_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bblur_fifo.sv =====
// ---------------------------------------------------------------------------
// bblur_fifo
// Short job queue between the front and the back of the box blur.
// ---------------------------------------------------------------------------
`default_nettype none

module bblur_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("Job queue holds more entries than its depth.");
`endif

endmodule

`default_nettype wire

// ===== rtl/bblur_front.sv =====
// ---------------------------------------------------------------------------
// bblur_front
// Accepts pixel and drain transfers, tracks frame position and queues jobs.
// ---------------------------------------------------------------------------
`default_nettype none

module bblur_front #(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int JOB_W = $bits(bblur_pkg::job_flags_t) + CW + bblur_pkg::PIX_W
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bblur_pkg::PIX_W-1:0]      s_axis_tdata,
  input  logic                             s_axis_tuser,
  input  logic                             cfg_we,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bblur_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             q_full,
  output logic                             q_push,
  output logic [JOB_W-1:0]                 q_data
);

  import bblur_pkg::*;

  logic [CW-1:0]    col_last;
  logic [ROW_W-1:0] row_last;
  logic [CW-1:0]    in_column;
  logic [ROW_W-1:0] in_row;
  logic             in_done;
  logic [CW-1:0]    out_col;
  logic [ROW_W-1:0] out_row;

  logic       accept;
  logic       pix_take;
  logic       drn_take;
  logic       pix_out;
  job_flags_t flags;
  logic [CW-1:0] job_col;
  rgb_t       px;

  function automatic logic [CW-1:0] col_last_of(input logic [WIDTH_REG_W-1:0] v);
    logic [31:0] ext;
    ext = 32'(v);
    if (ext == 32'd0) begin
      return '0;
    end else if (ext > 32'(MAX_WIDTH)) begin
      return CW'(MAX_WIDTH - 1);
    end else begin
      return CW'(ext - 32'd1);
    end
  endfunction

  function automatic logic [ROW_W-1:0] row_last_of(input logic [ROW_W-1:0] v);
    return (v == '0) ? '0 : v - 1'b1;
  endfunction

  assign s_axis_tready = !q_full;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign pix_take = accept && (s_axis_tuser == OP_PIXEL) && !in_done;
  assign drn_take = accept && (s_axis_tuser == OP_DRAIN) && in_done;
  assign q_push   = pix_take || drn_take;

  assign pix_out = (in_row > ROW_W'(1)) || ((in_row == ROW_W'(1)) && (in_column != '0));

  assign px.r = s_axis_tdata[CH_W-1:0];
  assign px.g = s_axis_tdata[2*CH_W-1:CH_W];
  assign px.b = s_axis_tdata[3*CH_W-1:2*CH_W];

  always_comb begin
    flags = '0;
    if (pix_take) begin
      flags.pixel    = 1'b1;
      flags.has_out  = pix_out;
      flags.interior = (out_row != '0) && (out_row < row_last)
                       && (out_col != '0) && (out_col < col_last);
      job_col        = in_column;
    end else begin
      flags.has_out   = 1'b1;
      flags.drain     = 1'b1;
      flags.sel_lower = (out_row == row_last);
      flags.last      = (out_row == row_last) && (out_col == col_last);
      job_col         = out_col;
    end
  end

  assign q_data = {flags, job_col, px};

  always_ff @(posedge clk) begin
    if (rst) begin
      col_last  <= col_last_of(WIDTH_RESET);
      row_last  <= row_last_of(HEIGHT_RESET);
      in_column <= '0;
      in_row    <= '0;
      in_done   <= 1'b0;
      out_col   <= '0;
      out_row   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          col_last <= col_last_of(cfg_data[WIDTH_REG_W-1:0]);
        end
        REG_IMAGE_HEIGHT: begin
          row_last <= row_last_of(cfg_data[ROW_W-1:0]);
        end
        default: begin
        end
      endcase
      in_column <= '0;
      in_row    <= '0;
      in_done   <= 1'b0;
      out_col   <= '0;
      out_row   <= '0;
    end else if (pix_take) begin
      if (in_column == col_last) begin
        in_column <= '0;
        if (in_row == row_last) begin
          in_done <= 1'b1;
        end else begin
          in_row <= in_row + 1'b1;
        end
      end else begin
        in_column <= in_column + 1'b1;
      end
      if (pix_out) begin
        if (out_col == col_last) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end else if (drn_take) begin
      if (flags.last) begin
        in_column <= '0;
        in_row    <= '0;
        in_done   <= 1'b0;
        out_col   <= '0;
        out_row   <= '0;
      end else if (out_col == col_last) begin
        out_col <= '0;
        out_row <= out_row + 1'b1;
      end else begin
        out_col <= out_col + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    in_column <= col_last)
    else $error("Input column ran past the last column.");

  a_out_row_bound: assert property (@(posedge clk) disable iff (rst)
    out_row <= row_last)
    else $error("Output row ran past the last row.");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (q_push && flags.last) |=>
      (in_column == '0 && in_row == '0 && !in_done && out_col == '0 && out_row == '0))
    else $error("Frame did not restart after its last output.");
`endif

endmodule

`default_nettype wire

// ===== rtl/bblur_back.sv =====
// ---------------------------------------------------------------------------
// bblur_back
// Line buffers, 3x3 window, channel sums and divide-by-nine output pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module bblur_back #(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int JOB_W = $bits(bblur_pkg::job_flags_t) + CW + bblur_pkg::PIX_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  logic [JOB_W-1:0]            q_data,
  output logic                        q_pop,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [bblur_pkg::PIX_W-1:0] m_axis_tdata,
  output logic                        m_axis_tlast
);

  import bblur_pkg::*;

  localparam int PROD_W = SUM_W + RECIP_W;

  logic          en;
  job_flags_t    head_flags;
  logic [CW-1:0] head_col;
  rgb_t          head_px;

  logic          s1_valid;
  job_flags_t    s1_flags;
  logic [CW-1:0] s1_col;
  rgb_t          s1_px;

  logic [2*PIX_W-1:0] rd_data;
  logic [2*PIX_W-1:0] wr_data;
  logic [2*PIX_W-1:0] eff;
  logic [2*PIX_W-1:0] byp_data;
  logic               byp;
  logic               ram_we;
  rgb_t               eff_upper;
  rgb_t               eff_lower;

  rgb_t win [3][3];

  logic s2_valid;
  logic s2_interior;
  logic s2_last;
  logic s2_drain;
  rgb_t s2_drain_px;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_g;
  logic [SUM_W-1:0] sum_b;

  logic s3_valid;
  logic s3_interior;
  logic s3_last;
  rgb_t s3_px;
  logic [SUM_W-1:0] s3_sum_r;
  logic [SUM_W-1:0] s3_sum_g;
  logic [SUM_W-1:0] s3_sum_b;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_g;
  logic [PROD_W-1:0] prod_b;

  assign {head_flags, head_col, head_px} = q_data;

  assign en    = !m_axis_tvalid || m_axis_tready;
  assign q_pop = en && !q_empty;

  // A read in the same cycle as a write to the same column sees the old
  // word, so the written word is forwarded instead.
  assign eff       = byp ? byp_data : rd_data;
  assign eff_upper = eff[2*PIX_W-1:PIX_W];
  assign eff_lower = eff[PIX_W-1:0];
  assign ram_we    = en && s1_valid && s1_flags.pixel;
  assign wr_data   = {eff_lower, s1_px};

  bblur_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col),
    .wdata (wr_data),
    .re    (q_pop),
    .raddr (head_col),
    .rdata (rd_data)
  );

  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        sum_r = sum_r + SUM_W'(win[r][c].r);
        sum_g = sum_g + SUM_W'(win[r][c].g);
        sum_b = sum_b + SUM_W'(win[r][c].b);
      end
    end
  end

  assign prod_r = PROD_W'(s3_sum_r) * PROD_W'(RECIP_NINE);
  assign prod_g = PROD_W'(s3_sum_g) * PROD_W'(RECIP_NINE);
  assign prod_b = PROD_W'(s3_sum_b) * PROD_W'(RECIP_NINE);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      s1_valid      <= q_pop;
      s2_valid      <= s1_valid && s1_flags.has_out;
      s3_valid      <= s2_valid;
      m_axis_tvalid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_flags <= head_flags;
      s1_col   <= head_col;
      s1_px    <= head_px;
      byp      <= q_pop && s1_valid && s1_flags.pixel && (head_col == s1_col);
      byp_data <= wr_data;

      if (s1_valid && s1_flags.pixel) begin
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= eff_upper;
        win[1][2] <= eff_lower;
        win[2][2] <= s1_px;
      end

      s2_interior <= s1_flags.interior;
      s2_last     <= s1_flags.last;
      s2_drain    <= s1_flags.drain;
      s2_drain_px <= s1_flags.sel_lower ? eff_lower : eff_upper;

      s3_interior <= s2_interior;
      s3_last     <= s2_last;
      s3_px       <= s2_drain ? s2_drain_px : win[1][1];
      s3_sum_r    <= sum_r;
      s3_sum_g    <= sum_g;
      s3_sum_b    <= sum_b;

      m_axis_tlast <= s3_last;
      if (s3_interior) begin
        m_axis_tdata <= {prod_b[RECIP_SHIFT +: CH_W], prod_g[RECIP_SHIFT +: CH_W],
                         prod_r[RECIP_SHIFT +: CH_W]};
      end else begin
        m_axis_tdata <= {s3_px.b, s3_px.g, s3_px.r};
      end
    end
  end

endmodule

`default_nettype wire
